[design/ooksnd_pkg.sv]
// shared types, constants and register codes for the ook pulse-width code sender
package ooksnd_pkg;

    // code word and length field widths
    localparam int CodeW       = 32;
    localparam int LenW        = 6;
    localparam int MaxCodeBits = 32;
    localparam int BitIdxW     = 5;

    // configuration field widths
    localparam int TicksW      = 10;
    localparam int RepW        = 4;
    localparam int SyncW       = 6;
    localparam int PhaseW      = 16;

    // queue between front and back
    localparam int QDepth      = 4;
    localparam int QAddrW      = 2;
    localparam int QCntW       = 3;

    // stream and register port widths
    localparam int InDataW     = 40;
    localparam int OutDataW    = 8;
    localparam int AddrW       = 4;
    localparam int RegIdxW     = 2;
    localparam int PDataW      = 32;

    // register indexes
    localparam logic [RegIdxW-1:0] RegLineFormat   = 2'd0;
    localparam logic [RegIdxW-1:0] RegShortTicks   = 2'd1;
    localparam logic [RegIdxW-1:0] RegRepeatCount  = 2'd2;
    localparam logic [RegIdxW-1:0] RegSyncMultiple = 2'd3;

    // register reset values
    localparam logic              RstLineFormat   = 1'b0;
    localparam logic [TicksW-1:0] RstShortTicks   = 10'd350;
    localparam logic [RepW-1:0]   RstRepeatCount  = 4'd10;
    localparam logic [SyncW-1:0]  RstSyncMultiple = 6'd36;

    // waveform phases
    typedef enum logic [5:0] {
        STG_IDLE       = 6'b000001,
        STG_START_HIGH = 6'b000010,
        STG_BIT_FIRST  = 6'b000100,
        STG_BIT_SECOND = 6'b001000,
        STG_SYNC_HIGH  = 6'b010000,
        STG_SYNC_LOW   = 6'b100000
    } stage_t;

    // one classified item in the queue
    typedef struct packed {
        logic             is_start;
        logic [CodeW-1:0] code;
        logic [LenW-1:0]  len;
    } q_entry_t;

    // queue fill status seen by front and back
    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    // live configuration
    typedef struct packed {
        logic              bell;
        logic [TicksW-1:0] short_ticks;
        logic [RepW-1:0]   repeat_count;
        logic [SyncW-1:0]  sync_multiple;
    } cfg_t;

endpackage

[design/ooksnd_front.sv]
// front end: takes input beats, classifies them and clamps the code length
module ooksnd_front (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ooksnd_pkg::InDataW-1:0]  s_tdata,   // code_word, code_length
    input  logic                            s_tuser,   // mode
    input  ooksnd_pkg::q_stat_t             q_stat,
    output logic                            push,
    output ooksnd_pkg::q_entry_t            entry
);

    logic [ooksnd_pkg::LenW-1:0] len_raw;

    // accept whenever the queue has room
    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    // classify and clamp the length to the code store size
    assign len_raw = s_tdata[ooksnd_pkg::CodeW +: ooksnd_pkg::LenW];

    always_comb
    begin
        entry.is_start = s_tuser;
        entry.code     = s_tdata[ooksnd_pkg::CodeW-1:0];
        if (len_raw > ooksnd_pkg::LenW'(ooksnd_pkg::MaxCodeBits))
        begin
            entry.len = ooksnd_pkg::LenW'(ooksnd_pkg::MaxCodeBits);
        end
        else
        begin
            entry.len = len_raw;
        end
    end

endmodule

[design/ooksnd_fifo.sv]
// short queue of classified items between front and back
module ooksnd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ooksnd_pkg::q_entry_t push_entry,
    input  logic                 pop,
    output ooksnd_pkg::q_entry_t head,
    output ooksnd_pkg::q_stat_t  q_stat
);

    ooksnd_pkg::q_entry_t              mem [ooksnd_pkg::QDepth];
    logic [ooksnd_pkg::QAddrW-1:0]     wr_ptr_reg;
    logic [ooksnd_pkg::QAddrW-1:0]     wr_ptr_next;
    logic [ooksnd_pkg::QAddrW-1:0]     rd_ptr_reg;
    logic [ooksnd_pkg::QAddrW-1:0]     rd_ptr_next;
    logic [ooksnd_pkg::QCntW-1:0]      count_reg;
    logic [ooksnd_pkg::QCntW-1:0]      count_next;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + ooksnd_pkg::QAddrW'(push);
        rd_ptr_next = rd_ptr_reg + ooksnd_pkg::QAddrW'(pop);
        count_next  = count_reg + ooksnd_pkg::QCntW'(push) - ooksnd_pkg::QCntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    assign head         = mem[rd_ptr_reg];
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == ooksnd_pkg::QCntW'(ooksnd_pkg::QDepth));

endmodule

[design/ooksnd_back.sv]
// back end: waveform sequencer and registered result beat
module ooksnd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ooksnd_pkg::cfg_t     cfg,
    input  ooksnd_pkg::q_entry_t head,
    input  ooksnd_pkg::q_stat_t  q_stat,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [ooksnd_pkg::OutDataW-1:0] m_tdata,   // line_level, busy_res
    output logic                 m_tlast               // transmission_done
);

    ooksnd_pkg::stage_t                  stage_reg, stage_next;
    logic [ooksnd_pkg::PhaseW-1:0]       ticks_reg, ticks_next;
    logic [ooksnd_pkg::LenW-1:0]         bitpos_reg, bitpos_next;
    logic [ooksnd_pkg::RepW-1:0]         reps_reg, reps_next;
    logic [ooksnd_pkg::CodeW-1:0]        code_reg, code_next;
    logic [ooksnd_pkg::LenW-1:0]         len_reg, len_next;
    logic                                pin_reg, pin_next;
    logic                                out_valid_reg, out_valid_next;
    logic                                out_level_reg, out_level_next;
    logic                                out_busy_reg, out_busy_next;
    logic                                out_done_reg, out_done_next;

    logic                                out_free;
    logic                                is_idle;
    logic                                do_load;
    ooksnd_pkg::stage_t                  tgt;
    ooksnd_pkg::stage_t                  after_bits;
    logic [ooksnd_pkg::PhaseW-1:0]       ticks_dec;
    logic [ooksnd_pkg::LenW-1:0]         bitpos_dec;
    logic [ooksnd_pkg::RepW-1:0]         reps_dec;
    logic [ooksnd_pkg::LenW-1:0]         bit_idx_full;
    logic                                cur_bit;
    logic [ooksnd_pkg::SyncW-1:0]        units;
    logic                                level;
    logic [ooksnd_pkg::TicksW-1:0]       unit_ticks;

    assign out_free   = !out_valid_reg || m_tready;
    assign is_idle    = (stage_reg == ooksnd_pkg::STG_IDLE);
    assign pop        = !q_stat.empty && (head.is_start || out_free);
    assign after_bits = cfg.bell ? ooksnd_pkg::STG_SYNC_LOW : ooksnd_pkg::STG_SYNC_HIGH;
    assign ticks_dec  = ticks_reg - ooksnd_pkg::PhaseW'(ticks_reg != '0);
    assign bitpos_dec = bitpos_reg - ooksnd_pkg::LenW'(bitpos_reg != '0);
    assign reps_dec   = reps_reg - ooksnd_pkg::RepW'(reps_reg != '0);
    assign unit_ticks = (cfg.short_ticks == '0) ? ooksnd_pkg::TicksW'(1) : cfg.short_ticks;

    // sequencer: start loads, ticks count down and advance the phase
    always_comb
    begin
        stage_next     = stage_reg;
        ticks_next     = ticks_reg;
        bitpos_next    = bitpos_reg;
        reps_next      = reps_reg;
        code_next      = code_reg;
        len_next       = len_reg;
        pin_next       = pin_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_level_next = out_level_reg;
        out_busy_next  = out_busy_reg;
        out_done_next  = out_done_reg;
        do_load        = 1'b0;
        tgt            = ooksnd_pkg::STG_IDLE;

        if (pop && head.is_start)
        begin
            if (is_idle)
            begin
                code_next   = head.code;
                len_next    = head.len;
                bitpos_next = head.len;
                reps_next   = (cfg.repeat_count == '0) ? ooksnd_pkg::RepW'(1)
                                                       : cfg.repeat_count;
                do_load     = 1'b1;
                if (cfg.bell)
                    tgt = ooksnd_pkg::STG_START_HIGH;
                else if (head.len != '0)
                    tgt = ooksnd_pkg::STG_BIT_FIRST;
                else
                    tgt = after_bits;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b1;
            out_level_next = 1'b0;
            out_busy_next  = 1'b0;
            out_done_next  = 1'b0;
            if (!is_idle)
            begin
                out_level_next = pin_reg;
                out_busy_next  = 1'b1;
                ticks_next     = ticks_dec;
                if (ticks_dec == '0)
                begin
                    unique case (stage_reg)
                        ooksnd_pkg::STG_START_HIGH:
                        begin
                            do_load = 1'b1;
                            tgt     = (bitpos_reg != '0) ? ooksnd_pkg::STG_BIT_FIRST
                                                         : after_bits;
                        end
                        ooksnd_pkg::STG_BIT_FIRST:
                        begin
                            do_load = 1'b1;
                            tgt     = ooksnd_pkg::STG_BIT_SECOND;
                        end
                        ooksnd_pkg::STG_BIT_SECOND:
                        begin
                            bitpos_next = bitpos_dec;
                            do_load     = 1'b1;
                            tgt         = (bitpos_dec != '0) ? ooksnd_pkg::STG_BIT_FIRST
                                                             : after_bits;
                        end
                        ooksnd_pkg::STG_SYNC_HIGH:
                        begin
                            do_load = 1'b1;
                            tgt     = ooksnd_pkg::STG_SYNC_LOW;
                        end
                        ooksnd_pkg::STG_SYNC_LOW:
                        begin
                            reps_next = reps_dec;
                            if (reps_dec != '0)
                            begin
                                // next repeat of the frame
                                bitpos_next = len_reg;
                                do_load     = 1'b1;
                                if (cfg.bell)
                                    tgt = ooksnd_pkg::STG_START_HIGH;
                                else if (len_reg != '0)
                                    tgt = ooksnd_pkg::STG_BIT_FIRST;
                                else
                                    tgt = after_bits;
                            end
                            else
                            begin
                                // last tick of the final repeat
                                stage_next    = ooksnd_pkg::STG_IDLE;
                                pin_next      = 1'b0;
                                ticks_next    = '0;
                                bitpos_next   = '0;
                                out_done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            stage_next = ooksnd_pkg::STG_IDLE;
                            pin_next   = 1'b0;
                            ticks_next = '0;
                        end
                    endcase
                end
            end
        end

        if (do_load)
        begin
            stage_next = tgt;
            pin_next   = level;
            ticks_next = ooksnd_pkg::PhaseW'(units) * ooksnd_pkg::PhaseW'(unit_ticks);
        end
    end

    // bit under the cursor of the phase being loaded
    assign bit_idx_full = bitpos_next - ooksnd_pkg::LenW'(1);
    assign cur_bit      = (bitpos_next != '0)
                          && code_next[bit_idx_full[ooksnd_pkg::BitIdxW-1:0]];

    // phase level and length in short units
    always_comb
    begin
        level = 1'b0;
        units = ooksnd_pkg::SyncW'(1);
        unique case (tgt)
            ooksnd_pkg::STG_START_HIGH:
            begin
                level = 1'b1;
            end
            ooksnd_pkg::STG_BIT_FIRST:
            begin
                if (cfg.bell)
                begin
                    level = 1'b0;
                    units = cur_bit ? ooksnd_pkg::SyncW'(2) : ooksnd_pkg::SyncW'(1);
                end
                else
                begin
                    level = 1'b1;
                    units = cur_bit ? ooksnd_pkg::SyncW'(3) : ooksnd_pkg::SyncW'(1);
                end
            end
            ooksnd_pkg::STG_BIT_SECOND:
            begin
                if (cfg.bell)
                begin
                    level = 1'b1;
                    units = cur_bit ? ooksnd_pkg::SyncW'(1) : ooksnd_pkg::SyncW'(2);
                end
                else
                begin
                    level = 1'b0;
                    units = cur_bit ? ooksnd_pkg::SyncW'(1) : ooksnd_pkg::SyncW'(3);
                end
            end
            ooksnd_pkg::STG_SYNC_HIGH:
            begin
                level = 1'b1;
            end
            ooksnd_pkg::STG_SYNC_LOW:
            begin
                level = 1'b0;
                units = (cfg.sync_multiple == '0) ? ooksnd_pkg::SyncW'(1)
                                                  : cfg.sync_multiple;
            end
            default:
            begin
                level = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg     <= ooksnd_pkg::STG_IDLE;
            ticks_reg     <= '0;
            bitpos_reg    <= '0;
            reps_reg      <= '0;
            len_reg       <= '0;
            pin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            stage_reg     <= stage_next;
            ticks_reg     <= ticks_next;
            bitpos_reg    <= bitpos_next;
            reps_reg      <= reps_next;
            len_reg       <= len_next;
            pin_reg       <= pin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        code_reg      <= code_next;
        out_level_reg <= out_level_next;
        out_busy_reg  <= out_busy_next;
        out_done_reg  <= out_done_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ooksnd_pkg::OutDataW-2){1'b0}}, out_busy_reg, out_level_reg};
    assign m_tlast  = out_done_reg;

endmodule

[design/ook_pulse_width_code_sender.sv]
// top level of the ook pulse-width code sender: register port, front, queue and back
// Takes one beat per clock on the input stream while the queue has room: a start beat
// (tuser high) loads a code word and length and begins the frame train, a tick beat (tuser low)
// advances the waveform by one timer tick and yields one result beat carrying the pin level,
// the busy flag and, on tlast, the end of the final repeat. A start that arrives while a
// transmission runs is dropped and gives no result. Items pass through a four-entry queue
// into the waveform sequencer: one item per cycle, ticks only while the result register
// is free; both sides may stall independently. Registers should be written only while idle.
module ook_pulse_width_code_sender (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ooksnd_pkg::InDataW-1:0]  s_tdata,   // [31:0] code_word, [37:32] code_length
    input  logic                            s_tuser,   // [0] mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ooksnd_pkg::OutDataW-1:0] m_tdata,   // [0] line_level, [1] busy_res
    output logic                            m_tlast,   // transmission_done
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ooksnd_pkg::AddrW-1:0]    paddr,
    input  logic [ooksnd_pkg::PDataW-1:0]   pwdata,
    output logic [ooksnd_pkg::PDataW-1:0]   prdata,
    output logic                            pready
);

    logic                                   line_format_reg;
    logic [ooksnd_pkg::TicksW-1:0]          short_ticks_reg;
    logic [ooksnd_pkg::RepW-1:0]            repeat_count_reg;
    logic [ooksnd_pkg::SyncW-1:0]           sync_multiple_reg;
    logic                                   wr_en;
    logic [ooksnd_pkg::RegIdxW-1:0]         reg_idx;
    ooksnd_pkg::cfg_t                       cfg;
    ooksnd_pkg::q_entry_t                   push_entry;
    ooksnd_pkg::q_entry_t                   head;
    ooksnd_pkg::q_stat_t                    q_stat;
    logic                                   push;
    logic                                   pop;

    // register port
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ooksnd_pkg::AddrW-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_format_reg   <= ooksnd_pkg::RstLineFormat;
            short_ticks_reg   <= ooksnd_pkg::RstShortTicks;
            repeat_count_reg  <= ooksnd_pkg::RstRepeatCount;
            sync_multiple_reg <= ooksnd_pkg::RstSyncMultiple;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                ooksnd_pkg::RegLineFormat:   line_format_reg   <= pwdata[0];
                ooksnd_pkg::RegShortTicks:   short_ticks_reg   <= pwdata[ooksnd_pkg::TicksW-1:0];
                ooksnd_pkg::RegRepeatCount:  repeat_count_reg  <= pwdata[ooksnd_pkg::RepW-1:0];
                ooksnd_pkg::RegSyncMultiple: sync_multiple_reg <= pwdata[ooksnd_pkg::SyncW-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_idx)
            ooksnd_pkg::RegLineFormat:   prdata = ooksnd_pkg::PDataW'(line_format_reg);
            ooksnd_pkg::RegShortTicks:   prdata = ooksnd_pkg::PDataW'(short_ticks_reg);
            ooksnd_pkg::RegRepeatCount:  prdata = ooksnd_pkg::PDataW'(repeat_count_reg);
            ooksnd_pkg::RegSyncMultiple: prdata = ooksnd_pkg::PDataW'(sync_multiple_reg);
            default:                     prdata = '0;
        endcase
    end

    assign cfg.bell          = line_format_reg;
    assign cfg.short_ticks   = short_ticks_reg;
    assign cfg.repeat_count  = repeat_count_reg;
    assign cfg.sync_multiple = sync_multiple_reg;

    // item classification
    ooksnd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .push     (push),
        .entry    (push_entry)
    );

    // item queue
    ooksnd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    // waveform sequencer
    ooksnd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // end of transmission is only flagged on a busy beat
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tlast || m_tdata[1]))
        else $error("transmission_done without busy");

    // an idle line is low
    a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[1]) |-> !m_tdata[0])
        else $error("line high while idle");

    // results only come from queued items
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && q_stat.empty) |=> !m_tvalid)
        else $error("result beat without a queued item");

endmodule

[sim/ooksnd_checker.sv]
// checker for the ook pulse-width code sender: mirrors the waveform and compares result beats
`timescale 1ns / 100ps
module ooksnd_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [ooksnd_pkg::InDataW-1:0]  s_tdata,   // [31:0] code_word, [37:32] code_length
    input  logic                            s_tuser,   // [0] mode
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ooksnd_pkg::OutDataW-1:0] m_tdata,   // [0] line_level, [1] busy_res
    input  logic                            m_tlast,   // transmission_done
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ooksnd_pkg::AddrW-1:0]    paddr,
    input  logic [ooksnd_pkg::PDataW-1:0]   pwdata,
    input  logic                            pready,
    output int                              fail_count,
    output int                              pending,
    output logic                            tx_active
);
    import ooksnd_pkg::*;

    // one result beat as the pin should look
    typedef struct packed {
        logic level;
        logic busy;
        logic done;
    } pin_sample_t;

    // mirrored registers
    logic              bell_fmt   = RstLineFormat;
    logic [TicksW-1:0] unit_len   = RstShortTicks;
    logic [RepW-1:0]   frame_reps = RstRepeatCount;
    logic [SyncW-1:0]  sync_units = RstSyncMultiple;

    // mirrored waveform state
    stage_t            stg        = STG_IDLE;
    logic [PhaseW-1:0] ticks_left = '0;
    logic [LenW-1:0]   bits_left  = '0;
    logic [RepW-1:0]   reps_left  = '0;
    logic [CodeW-1:0]  code_q     = '0;
    logic [LenW-1:0]   len_q      = '0;
    logic              pin        = 1'b0;

    pin_sample_t expected_samples[$];
    int          mismatches = 0;
    int          pending_q  = 0;
    logic        active_q   = 1'b0;

    assign fail_count = mismatches;
    assign pending    = pending_q;
    assign tx_active  = active_q;

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // ticks in one short unit, zero acts as one
    function automatic int unit_ticks();
        return (unit_len == '0) ? 1 : int'(unit_len);
    endfunction

    // code bit now on the line, positions past the word read as zero
    function automatic logic code_bit();
        logic [LenW-1:0] pos;
        pos = bits_left - LenW'(1);
        if (bits_left == '0 || bits_left > LenW'(CodeW))
            return 1'b0;
        return code_q[pos[BitIdxW-1:0]];
    endfunction

    // load a phase: its pin level and its length in ticks
    function automatic void enter_phase(stage_t s);
        int   units;
        logic lvl;
        logic one;
        one   = code_bit();
        units = 1;
        lvl   = 1'b0;
        case (s)
            STG_START_HIGH: lvl = 1'b1;
            STG_BIT_FIRST:
            begin
                lvl   = !bell_fmt;
                units = bell_fmt ? (one ? 2 : 1) : (one ? 3 : 1);
            end
            STG_BIT_SECOND:
            begin
                lvl   = bell_fmt;
                units = bell_fmt ? (one ? 1 : 2) : (one ? 1 : 3);
            end
            STG_SYNC_HIGH:  lvl = 1'b1;
            STG_SYNC_LOW:   units = (sync_units == '0) ? 1 : int'(sync_units);
            default:
            begin
                s     = STG_IDLE;
                units = 0;
            end
        endcase
        stg        = s;
        pin        = lvl;
        ticks_left = PhaseW'(units * unit_ticks());
    endfunction

    // socket goes to the high sync pulse, bell straight to the low sync
    function automatic void enter_sync();
        enter_phase(bell_fmt ? STG_SYNC_LOW : STG_SYNC_HIGH);
    endfunction

    // first phase of a frame
    function automatic void open_frame();
        bits_left = len_q;
        if (bell_fmt)
            enter_phase(STG_START_HIGH);
        else if (bits_left != '0)
            enter_phase(STG_BIT_FIRST);
        else
            enter_sync();
    endfunction

    // phase boundary, returns high when the final repeat has ended
    function automatic logic next_phase();
        case (stg)
            STG_START_HIGH:
            begin
                if (bits_left != '0)
                    enter_phase(STG_BIT_FIRST);
                else
                    enter_sync();
            end
            STG_BIT_FIRST:  enter_phase(STG_BIT_SECOND);
            STG_BIT_SECOND:
            begin
                if (bits_left != '0)
                    bits_left--;
                if (bits_left != '0)
                    enter_phase(STG_BIT_FIRST);
                else
                    enter_sync();
            end
            STG_SYNC_HIGH:  enter_phase(STG_SYNC_LOW);
            STG_SYNC_LOW:
            begin
                if (reps_left != '0)
                    reps_left--;
                if (reps_left != '0)
                    open_frame();
                else
                begin
                    stg        = STG_IDLE;
                    pin        = 1'b0;
                    ticks_left = '0;
                    bits_left  = '0;
                    return 1'b1;
                end
            end
            default:
            begin
                stg        = STG_IDLE;
                pin        = 1'b0;
                ticks_left = '0;
            end
        endcase
        return 1'b0;
    endfunction

    // start beats load a transmission when idle, tick beats yield one pin sample
    function automatic void predict_pin_sample(input logic is_start,
                                               input logic [CodeW-1:0] code,
                                               input logic [LenW-1:0] len);
        pin_sample_t smp;
        if (is_start)
        begin
            if (stg == STG_IDLE)
            begin
                code_q    = code;
                len_q     = (len > LenW'(MaxCodeBits)) ? LenW'(MaxCodeBits) : len;
                reps_left = (frame_reps == '0) ? RepW'(1) : frame_reps;
                open_frame();
            end
            return;
        end
        smp = '0;
        if (stg != STG_IDLE)
        begin
            smp.level = pin;
            smp.busy  = 1'b1;
            if (ticks_left != '0)
                ticks_left--;
            if (ticks_left == '0)
                smp.done = next_phase();
        end
        expected_samples.push_back(smp);
    endfunction

    // register writes, result compare, then prediction of the accepted input beat
    always @(posedge clk)
    begin
        pin_sample_t want;
        pin_sample_t got;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[AddrW-1:2])
                    RegLineFormat:   bell_fmt   = pwdata[0];
                    RegShortTicks:   unit_len   = pwdata[TicksW-1:0];
                    RegRepeatCount:  frame_reps = pwdata[RepW-1:0];
                    RegSyncMultiple: sync_units = pwdata[SyncW-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = '{level: m_tdata[0], busy: m_tdata[1], done: m_tlast};
                if (expected_samples.size() == 0)
                    report($sformatf("result beat with none expected: level %b busy %b done %b",
                                     got.level, got.busy, got.done));
                else
                begin
                    want = expected_samples.pop_front();
                    if (got !== want)
                        report($sformatf("level %b/%b busy %b/%b done %b/%b (got/expected)",
                                         got.level, want.level, got.busy, want.busy,
                                         got.done, want.done));
                end
            end
            if (s_tvalid && s_tready)
                predict_pin_sample(s_tuser, s_tdata[CodeW-1:0], s_tdata[CodeW +: LenW]);
        end
        pending_q <= expected_samples.size();
        active_q  <= (stg != STG_IDLE);
    end

endmodule

[sim/tb_top.sv]
// testbench top for the ook pulse-width code sender: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb_top;
    import ooksnd_pkg::*;

    localparam int   CycleLimit    = 2_000_000;
    localparam int   RandomPhases  = 6;
    localparam int   ItemsPerPhase = 100;
    localparam int   SettleCycles  = 8;
    localparam logic StartBeat     = 1'b1;
    localparam logic TickBeat      = 1'b0;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic                m_tlast;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [AddrW-1:0]    paddr    = '0;
    logic [PDataW-1:0]   pwdata   = '0;
    logic [PDataW-1:0]   prdata;
    logic                pready;

    int   fail_count;
    int   pending;
    logic tx_active;
    logic idle_on = 1'b1;
    int   cycles  = 0;

    ook_pulse_width_code_sender u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ooksnd_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending),
        .tx_active  (tx_active)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // run guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("FAIL ook_pulse_width_code_sender");
            $finish;
        end
    end

    // result side: stall bursts and calm stretches
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 29) == 0)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(40, 160)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // one input beat, with an occasional gap in front of it
    task automatic push_beat(input logic is_start, input logic [CodeW-1:0] code,
                             input logic [LenW-1:0] len);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_start;
        s_tdata  <= {{(InDataW - CodeW - LenW){1'b0}}, len, code};
        do @(posedge clk); while (!s_tready);
    endtask

    // tick beats carry random filler in the unused fields
    task automatic send_tick();
        push_beat(TickBeat, CodeW'($urandom), LenW'($urandom));
    endtask

    // hold the input side until every predicted sample has been taken
    task automatic wait_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // tick until the transmission ends, then let the block go quiet
    task automatic settle();
        do send_tick(); while (tx_active);
        wait_results();
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic reg_write(input logic [RegIdxW-1:0] idx, input logic [PDataW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic bell, input int ticks, input int reps, input int sync);
        reg_write(RegLineFormat, PDataW'(bell));
        reg_write(RegShortTicks, PDataW'(ticks));
        reg_write(RegRepeatCount, PDataW'(reps));
        reg_write(RegSyncMultiple, PDataW'(sync));
    endtask

    // mostly short codes, sometimes empty, full or oversized
    function automatic logic [LenW-1:0] rand_len();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return LenW'(MaxCodeBits);
            2:       return LenW'($urandom_range(MaxCodeBits + 1, (1 << LenW) - 1));
            default: return LenW'($urandom_range(1, 6));
        endcase
    endfunction

    // stimulus
    initial
    begin
        int done_items;
        int reps;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle tick at reset settings
        send_tick();
        wait_results();

        // socket, one-tick units, a busy start that must be dropped
        set_config(1'b0, 1, 1, 1);
        push_beat(StartBeat, 32'h0000_00A5, 6'd8);
        repeat (3) send_tick();
        push_beat(StartBeat, '1, 6'd3);
        wait_results();
        settle();
        push_beat(StartBeat, '0, '0);
        settle();

        // bell format: full word, oversized length, empty frame
        set_config(1'b1, 2, 2, 3);
        push_beat(StartBeat, '1, 6'd32);
        settle();
        push_beat(StartBeat, 32'h8000_0001, 6'd40);
        settle();
        push_beat(StartBeat, CodeW'($urandom), '0);
        settle();

        // zero registers act as one
        set_config(1'b0, 0, 0, 0);
        push_beat(StartBeat, '0, 6'd4);
        settle();

        // longest unit, then most repeats with longest sync
        set_config(1'b0, 1023, 1, 1);
        push_beat(StartBeat, CodeW'($urandom), '0);
        settle();
        set_config(1'b1, 1, 15, 63);
        push_beat(StartBeat, CodeW'($urandom), 6'd32);
        settle();

        // random phases, each under its own settings; the last one without idling
        for (int ph = 0; ph < RandomPhases; ph++)
        begin
            if (ph == RandomPhases - 1)
                idle_on <= 1'b0;
            reps = ($urandom_range(0, 4) == 0) ? 15 : $urandom_range(1, 3);
            set_config(1'($urandom_range(0, 1)), (reps == 15) ? 1 : $urandom_range(0, 3), reps,
                       ($urandom_range(0, 4) == 0) ? 63 : $urandom_range(0, 4));
            done_items = 0;
            while (done_items < ItemsPerPhase)
            begin
                if ($urandom_range(0, 99) == 0)
                    wait_results();
                if ($urandom_range(0, tx_active ? 24 : 2) == 0)
                begin
                    if (!tx_active)
                        done_items++;
                    push_beat(StartBeat, CodeW'($urandom), rand_len());
                end
                else
                begin
                    send_tick();
                    done_items++;
                end
            end
            settle();
        end

        repeat (2 * SettleCycles) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS ook_pulse_width_code_sender");
        else
            $display("FAIL ook_pulse_width_code_sender");
        $finish;
    end

endmodule

[filelist.f]
design/ooksnd_pkg.sv
design/ooksnd_front.sv
design/ooksnd_fifo.sv
design/ooksnd_back.sv
design/ook_pulse_width_code_sender.sv
sim/ooksnd_checker.sv
sim/tb_top.sv
